@@ src/tcw_pkg.sv @@
// tcw_pkg: shared constants, command codes and the result struct of the text console writer
// no dependencies; used by the interfaces, the screen RAM, the sequencer and the top level
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // transaction field widths
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CELL_W = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT        = 2'd0,
        CMD_CLEAR      = 2'd1,
        CMD_SET_CURSOR = 2'd2,
        CMD_READ       = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_data;
    } t_result;

endpackage

@@ src/tcw_intf.sv @@
// tcw_cmd_if / tcw_rsp_if: valid-ready channels of the text console writer
// depends on tcw_pkg for the field widths
interface tcw_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::CMD_W-1:0]   cmd;
    logic [tcw_pkg::CHAR_W-1:0]  char_code;
    logic [tcw_pkg::ATTR_W-1:0]  attr;
    logic [tcw_pkg::COL_W-1:0]   col;
    logic [tcw_pkg::ROW_W-1:0]   row;

    modport source (output valid, cmd, char_code, attr, col, row, input ready);
    modport sink   (input valid, cmd, char_code, attr, col, row, output ready);
endinterface

interface tcw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcw_pkg::COL_W-1:0]   cursor_col;
    logic [tcw_pkg::ROW_W-1:0]   cursor_row;
    logic [tcw_pkg::CELL_W-1:0]  cell_data;

    modport source (output valid, cursor_col, cursor_row, cell_data, input ready);
    modport sink   (input valid, cursor_col, cursor_row, cell_data, output ready);
endinterface

@@ src/tcw_screen_ram.sv @@
// tcw_screen_ram: screen cell store, one write and one registered read port
// depends on tcw_pkg for the cell width
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

@@ src/tcw_seq.sv @@
// tcw_seq: command sequencer of the text console writer: cursor, scroll and fill sweeps
// depends on tcw_pkg and tcw_cmd_if; drives the ports of tcw_screen_ram
module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tcw_cmd_if.sink                     i_cmd,
    output logic                        o_res_valid,
    output tcw_pkg::t_result            o_res,
    input  logic                        i_res_take,
    output logic                        o_we,
    output logic [ADDR_W-1:0]           o_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_wdata,
    output logic                        o_re,
    output logic [ADDR_W-1:0]           o_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_rdata
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int CUR_COL_W  = $clog2(COLUMNS + 1);
    localparam int CUR_ROW_W  = $clog2(ROWS);
    localparam int RES_COL_W  = tcw_pkg::COL_W;
    localparam int RES_ROW_W  = tcw_pkg::ROW_W;
    localparam logic [ADDR_W-1:0] LAST_MOVE = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_READ = 6'b000100,
        S_MOVE = 6'b001000,
        S_FILL = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                      r_state, n_state;
    logic [ADDR_W-1:0]           r_addr, n_addr;
    logic [tcw_pkg::CELL_W-1:0]  r_fill, n_fill;
    logic                        r_init, n_init;
    logic [CUR_COL_W-1:0]        r_cur_col, n_cur_col;
    logic [CUR_ROW_W-1:0]        r_cur_row, n_cur_row;
    logic [tcw_pkg::CELL_W-1:0]  r_data, n_data;

    // latched transaction
    tcw_pkg::t_cmd               r_cmd;
    logic [tcw_pkg::CHAR_W-1:0]  r_ch;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr;
    logic [tcw_pkg::COL_W-1:0]   r_col;
    logic [tcw_pkg::ROW_W-1:0]   r_row;

    logic                        accept;
    logic [CUR_ROW_W:0]          row_inc;
    logic                        nl_scroll;
    logic                        col_full;
    logic [CUR_ROW_W:0]          row_a;
    logic [CUR_ROW_W-1:0]        put_row;
    logic [CUR_COL_W-1:0]        put_col;
    logic [ADDR_W-1:0]           put_addr;
    logic                        rd_ok;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           move_raddr;

    assign i_cmd.ready = (r_state == S_IDLE) || ((r_state == S_DONE) && i_res_take);
    assign accept      = i_cmd.valid && i_cmd.ready;

    // cursor arithmetic
    assign row_inc   = {1'b0, r_cur_row} + (CUR_ROW_W + 1)'(1);
    assign nl_scroll = 32'(row_inc) >= ROWS;
    assign col_full  = 32'(r_cur_col) >= COLUMNS;
    assign row_a     = col_full ? row_inc : {1'b0, r_cur_row};
    // row overflow without a newline wraps to the top
    assign put_row   = (32'(row_a) >= ROWS) ? '0 : CUR_ROW_W'(row_a);
    assign put_col   = col_full ? '0 : r_cur_col;
    assign put_addr  = ADDR_W'(32'(put_row) * COLUMNS + 32'(put_col));

    assign rd_ok      = (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS);
    assign rd_addr    = ADDR_W'(32'(r_row) * COLUMNS + 32'(r_col));
    // scroll reads one row ahead of the write pointer
    assign move_raddr = ADDR_W'(32'(r_addr) + COLUMNS + 1);

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_fill    = r_fill;
        n_init    = r_init;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_data    = r_data;
        o_we      = 1'b0;
        o_waddr   = r_addr;
        o_wdata   = r_fill;
        o_re      = 1'b0;
        o_raddr   = move_raddr;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_data = '0;
                case (r_cmd)
                    tcw_pkg::CMD_PUT: begin
                        if (r_ch == tcw_pkg::CHAR_NEWLINE) begin
                            n_cur_col = '0;
                            if (nl_scroll) begin
                                n_cur_row = CUR_ROW_W'(ROWS - 1);
                                n_addr    = '0;
                                n_fill    = {r_attr, tcw_pkg::CHAR_SPACE};
                                o_re      = 1'b1;
                                o_raddr   = ADDR_W'(COLUMNS);
                                n_state   = S_MOVE;
                            end else begin
                                n_cur_row = CUR_ROW_W'(row_inc);
                                n_state   = S_DONE;
                            end
                        end else begin
                            o_we      = 1'b1;
                            o_waddr   = put_addr;
                            o_wdata   = {r_attr, r_ch};
                            n_cur_col = put_col + CUR_COL_W'(1);
                            n_cur_row = put_row;
                            n_state   = S_DONE;
                        end
                    end
                    tcw_pkg::CMD_CLEAR: begin
                        n_addr    = '0;
                        n_fill    = {r_attr, tcw_pkg::CHAR_SPACE};
                        n_cur_col = '0;
                        n_cur_row = '0;
                        n_state   = S_FILL;
                    end
                    tcw_pkg::CMD_SET_CURSOR: begin
                        n_cur_col = (32'(r_col) < COLUMNS) ? CUR_COL_W'(r_col)
                                                           : CUR_COL_W'(COLUMNS - 1);
                        n_cur_row = (32'(r_row) < ROWS) ? CUR_ROW_W'(r_row)
                                                        : CUR_ROW_W'(ROWS - 1);
                        n_state   = S_DONE;
                    end
                    tcw_pkg::CMD_READ: begin
                        if (rd_ok) begin
                            o_re    = 1'b1;
                            o_raddr = rd_addr;
                            n_state = S_READ;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                n_data  = i_rdata;
                n_state = S_DONE;
            end
            S_MOVE: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                if (r_addr == LAST_MOVE) begin
                    n_addr  = ADDR_W'(CELLS - COLUMNS);
                    n_state = S_FILL;
                end else begin
                    o_re   = 1'b1;
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_FILL: begin
                o_we = 1'b1;
                if (r_addr == LAST_CELL) begin
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_addr = r_addr + ADDR_W'(1);
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset clears the store by the same fill sweep
            r_state   <= S_FILL;
            r_addr    <= '0;
            r_fill    <= {tcw_pkg::RESET_ATTR, tcw_pkg::CHAR_SPACE};
            r_init    <= 1'b1;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_data    <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_fill    <= n_fill;
            r_init    <= n_init;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_data    <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= tcw_pkg::t_cmd'(i_cmd.cmd);
            r_ch   <= i_cmd.char_code;
            r_attr <= i_cmd.attr;
            r_col  <= i_cmd.col;
            r_row  <= i_cmd.row;
        end
    end

    assign o_res_valid      = (r_state == S_DONE);
    assign o_res.cursor_col = RES_COL_W'(r_cur_col);
    assign o_res.cursor_row = RES_ROW_W'(r_cur_row);
    assign o_res.cell_data  = r_data;

endmodule

@@ src/text_console_writer_core.sv @@
// Character-cell text console writer. Commands arrive one transaction at a time on i_cmd
// (put character, clear, set cursor, read cell) and each gives exactly one transaction on
// o_rsp with the cursor after the command and, for a read, the cell (attribute high byte,
// character low byte). The screen lives in a COLUMNS x ROWS cell memory with one write and
// one registered read port; the cursor is held in registers. A newline off the bottom row
// scrolls: the memory is copied up one row and the last row filled, one cell per cycle
// through the single write port; clear sweeps every cell the same way. After reset the
// store is cleared to spaces with attribute 0x07 by a sweep during which no command is
// taken. A read outside the screen gives a zero cell and does not access the memory.
// A finished result waits in an output register, so the next command is taken meanwhile.
// Depends on tcw_pkg, tcw_cmd_if, tcw_rsp_if, tcw_screen_ram and tcw_seq.
module text_console_writer_core #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcw_cmd_if.sink     i_cmd,
    tcw_rsp_if.source   o_rsp
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

    logic                        res_valid;
    tcw_pkg::t_result            res;
    logic                        res_take;

    logic                        r_out_valid;
    tcw_pkg::t_result            r_out;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata)
    );

    // output register: free when empty or being drained this cycle
    assign res_take = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_take) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_col = r_out.cursor_col;
    assign o_rsp.cursor_row = r_out.cursor_row;
    assign o_rsp.cell_data  = r_out.cell_data;

    // a command is decoded in the cycle after it is taken, so no back-to-back accept
    a_no_double_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command taken while the previous one is still being decoded");

    // reported cursor row never beyond the bottom row
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (32'(res.cursor_row) < ROWS))
        else $error("cursor row past the bottom row");

    // reported cursor column never past the full-row mark
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (32'(res.cursor_col) <= COLUMNS))
        else $error("cursor column past the end of the row");

    // a result held back by the sink stays in the output register
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result lost or overwritten");

endmodule
